FILE: hw/rtl/life_automaton_row_step_macros.svh
// ----------------------------------------------------------------------------
// life_automaton_row_step_macros.svh
// Assertion shorthands for the row-step RTL, used by lar_outq.
// ----------------------------------------------------------------------------
`ifndef LIFE_AUTOMATON_ROW_STEP_MACROS_SVH
`define LIFE_AUTOMATON_ROW_STEP_MACROS_SVH

// same-cycle implication, disabled in reset
`define LAR_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define LAR_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/lar_pkg.sv
// ----------------------------------------------------------------------------
// lar_pkg
// Types and constants for the life automaton row step.
// ----------------------------------------------------------------------------
`default_nettype none

package lar_pkg;

  localparam int ROW_W         = 64;
  localparam int WIDTH_W       = 7;
  localparam int MAX_WIDTH_DEF = 64;
  localparam int QDEPTH        = 4;

  localparam int BIRTH_COUNT   = 3;
  localparam int SURVIVE_COUNT = 2;

  localparam int APB_ADDR_W    = 3;
  localparam int APB_DATA_W    = 32;
  localparam int REG_IDX_W     = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_BOARD_WIDTH = REG_IDX_W'(0);
  localparam logic [WIDTH_W-1:0]   BOARD_WIDTH_RST = WIDTH_W'(64);

  typedef struct packed {
    logic [ROW_W-1:0] row_cells;
    logic             last_row;
  } lar_in_t;

  typedef struct packed {
    logic [ROW_W-1:0] next_row;
    logic             board_done;
  } lar_out_t;

  // results pushed into the output queue in one cycle
  typedef struct packed {
    logic mid;   // result for the held row
    logic last;  // result for the final row itself
  } lar_push_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lar_lane.sv
// ----------------------------------------------------------------------------
// lar_lane
// B3/S23 rule for one cell from its eight neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module lar_lane import lar_pkg::*; (
  input  logic [7:0] nbrs,
  input  logic       self_alive,
  output logic       next_alive
);

  logic [3:0] n;

  always_comb begin
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(nbrs[i]);
    end
  end

  assign next_alive = (n == 4'(BIRTH_COUNT)) || (self_alive && (n == 4'(SURVIVE_COUNT)));

endmodule

`default_nettype wire

FILE: hw/rtl/lar_row.sv
// ----------------------------------------------------------------------------
// lar_row
// One lane per column; merges lane outputs into a masked next-state row.
// ----------------------------------------------------------------------------
`default_nettype none

module lar_row import lar_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic [MAX_WIDTH-1:0] up,
  input  logic [MAX_WIDTH-1:0] mid,
  input  logic [MAX_WIDTH-1:0] dn,
  input  logic [MAX_WIDTH-1:0] mask,
  output logic [MAX_WIDTH-1:0] next_row
);

  logic [MAX_WIDTH+1:0] pu, pm, pd;
  logic [MAX_WIDTH-1:0] lanes;

  // zero padding gives dead cells past both edges
  assign pu = {1'b0, up  & mask, 1'b0};
  assign pm = {1'b0, mid & mask, 1'b0};
  assign pd = {1'b0, dn  & mask, 1'b0};

  for (genvar j = 0; j < MAX_WIDTH; j++) begin : g_lane
    lar_lane u_lane (
      .nbrs       ({pu[j], pu[j+1], pu[j+2], pm[j], pm[j+2], pd[j], pd[j+1], pd[j+2]}),
      .self_alive (pm[j+1]),
      .next_alive (lanes[j])
    );
  end

  assign next_row = lanes & mask;

endmodule

`default_nettype wire

FILE: hw/rtl/lar_outq.sv
// ----------------------------------------------------------------------------
// lar_outq
// Result queue; takes up to two results a cycle, hands out one while out_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none

`include "life_automaton_row_step_macros.svh"

module lar_outq import lar_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  lar_push_t push,
  input  lar_out_t  mid_res,
  input  lar_out_t  last_res,
  output logic      space,
  output logic      out_valid,
  input  logic      out_stall,
  output lar_out_t  out_data
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = PTR_W + 1;

  lar_out_t         mem [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] n_push;
  logic             pop;

  assign pop       = out_valid && !out_stall;
  assign n_push    = CNT_W'(push.mid) + CNT_W'(push.last);
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign space     = (count <= CNT_W'(QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.mid || push.last) begin
      mem[wr_ptr] <= push.mid ? mid_res : last_res;
    end
    if (push.mid && push.last) begin
      mem[wr_ptr + PTR_W'(1)] <= last_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(n_push);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count + n_push - CNT_W'(pop);
    end
  end

  `LAR_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(QDEPTH), "queue overflow")
  `LAR_ASSERT_NOW(a_push_space, clk, rst, push.mid || push.last, space, "push without room")
  `LAR_ASSERT_NEXT(a_double_push, clk, rst, push.mid && push.last && !pop,
                   count == $past(count) + CNT_W'(2), "double push miscounted")

endmodule

`default_nettype wire

FILE: hw/rtl/life_automaton_row_step.sv
// ----------------------------------------------------------------------------
// life_automaton_row_step
// One B3/S23 generation computed row by row, one lane per column.
// ----------------------------------------------------------------------------
// channel   dir  handshake                 payload
// cells     in   cells_valid/cells_stall   row_cells, last_row
// result    out  result_valid/result_stall next_row, board_done
// apb       cfg  psel/penable/pready       board_width at byte address 0
//
// A row is taken every cycle while the result queue has two free slots;
// its result is queued when the next row is taken; a final row also queues
// its own result, both at once when a row is held. The output port moves
// one result a cycle while not stalled. Reset clears the held rows and the
// queue; board_width returns to 64. A stalled result holds; input stalls in
// reset and while fewer than two queue slots are free.
// ----------------------------------------------------------------------------
`default_nettype none

module life_automaton_row_step import lar_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cells_valid,
  output logic                  cells_stall,
  input  lar_in_t               cells,
  output logic                  result_valid,
  input  logic                  result_stall,
  output lar_out_t              result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam logic [WIDTH_W-1:0] MAXW = WIDTH_W'(MAX_WIDTH);

  logic [WIDTH_W-1:0]   board_width;
  logic [WIDTH_W-1:0]   w_eff;
  logic [MAX_WIDTH-1:0] mask;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  logic [MAX_WIDTH-1:0] row_above;
  logic [MAX_WIDTH-1:0] row_middle;
  logic                 middle_valid;
  logic [MAX_WIDTH-1:0] row_in;
  logic [MAX_WIDTH-1:0] up_last;
  logic [MAX_WIDTH-1:0] gen_mid;
  logic [MAX_WIDTH-1:0] gen_last;

  logic                 accept;
  logic                 space;
  lar_push_t            push;
  lar_out_t             mid_res;
  lar_out_t             last_res;

  // configuration
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      board_width <= BOARD_WIDTH_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_BOARD_WIDTH: board_width <= pwdata[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_BOARD_WIDTH: prdata = APB_DATA_W'(board_width);
      default: ;
    endcase
  end

  assign w_eff = (board_width > MAXW) ? MAXW : board_width;

  always_comb begin
    for (int j = 0; j < MAX_WIDTH; j++) begin
      mask[j] = (WIDTH_W'(j) < w_eff);
    end
  end

  // row window
  assign cells_stall = rst || !space;
  assign accept      = cells_valid && !cells_stall;
  assign row_in      = cells.row_cells[MAX_WIDTH-1:0] & mask;
  assign up_last     = middle_valid ? row_middle : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_above    <= '0;
      row_middle   <= '0;
      middle_valid <= 1'b0;
    end else if (accept) begin
      if (cells.last_row) begin
        row_above    <= '0;
        row_middle   <= '0;
        middle_valid <= 1'b0;
      end else begin
        row_above    <= up_last;
        row_middle   <= row_in;
        middle_valid <= 1'b1;
      end
    end
  end

  lar_row #(.MAX_WIDTH(MAX_WIDTH)) u_row_mid (
    .up       (row_above),
    .mid      (row_middle),
    .dn       (row_in),
    .mask     (mask),
    .next_row (gen_mid)
  );

  lar_row #(.MAX_WIDTH(MAX_WIDTH)) u_row_last (
    .up       (up_last),
    .mid      (row_in),
    .dn       ('0),
    .mask     (mask),
    .next_row (gen_last)
  );

  assign push.mid  = accept && middle_valid;
  assign push.last = accept && cells.last_row;

  assign mid_res.next_row    = ROW_W'(gen_mid);
  assign mid_res.board_done  = 1'b0;
  assign last_res.next_row   = ROW_W'(gen_last);
  assign last_res.board_done = 1'b1;

  lar_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .mid_res   (mid_res),
    .last_res  (last_res),
    .space     (space),
    .out_valid (result_valid),
    .out_stall (result_stall),
    .out_data  (result)
  );

endmodule

`default_nettype wire
